### hw/rtl/fasta_pack_and_index_macros.svh
// Assertion macros for the FASTA packer and indexer.
// Used by the parser and the result queue; no other dependencies.
`ifndef FASTA_PACK_AND_INDEX_MACROS_SVH
`define FASTA_PACK_AND_INDEX_MACROS_SVH

`ifndef SYNTHESIS

`define FPI_ASSERT(lbl, clkn, rstn, prop) \
  lbl: assert property (@(posedge clkn) disable iff (!rstn) (prop)) \
    else $error("fasta_pack_and_index: assertion failed");

`define FPI_ASSERT_STEP(lbl, clkn, rstn, pre, post) \
  lbl: assert property (@(posedge clkn) disable iff (!rstn) (pre) |=> (post)) \
    else $error("fasta_pack_and_index: assertion failed");

`else

`define FPI_ASSERT(lbl, clkn, rstn, prop)

`define FPI_ASSERT_STEP(lbl, clkn, rstn, pre, post)

`endif

`endif

### hw/rtl/fpi_pkg.sv
// Shared types, constants and helpers for the FASTA packer and indexer.
// No dependencies.
`timescale 1ns / 1ps

package fpi_pkg;

  localparam int POS_BITS   = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;

  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_NUL  = 8'h00;

  typedef enum logic [1:0] {
    M_LINE = 2'd0,
    M_HEAD = 2'd1,
    M_SEQ  = 2'd2,
    M_PEND = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        rec_valid;
    logic [31:0] rec_offset;
    logic [31:0] rec_length;
    logic [31:0] max_length;
    logic        error;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      push;
    logic      dual;
    out_item_t first;
    out_item_t second;
  } res_push_t;

  function automatic logic [31:0] pos_to_out(pos_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

endpackage

### hw/rtl/fpi_parse.sv
// Parser state, position counters and result formation for one byte per cycle while accept is high.
// Depends on fpi_pkg and fasta_pack_and_index_macros.svh.
`timescale 1ns / 1ps
`include "fasta_pack_and_index_macros.svh"

module fpi_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              accept,
  input  fpi_pkg::in_item_t in_data,
  output fpi_pkg::res_push_t res
);
  import fpi_pkg::*;

  logic [7:0] delim_r;
  mode_t      mode_r, mode_nxt, mode_fsm;
  pos_t       wpos_r, wpos_nxt;
  pos_t       hash_r, hash_nxt;
  pos_t       long_r, long_nxt;
  logic       seen_r, seen_nxt;
  logic       fault_r, fault_nxt;

  logic       is_gt, is_nl, eof;
  logic       do_close, do_wr, set_hash, tail_fault;
  logic [7:0] wr_byte;

  pos_t       p1, pw, p2, len;
  logic       sat0, satw, first_bad;

  assign is_gt = (in_data.in_byte == CH_GT);
  assign is_nl = (in_data.in_byte == CH_NL);
  assign eof   = in_data.end_of_file;

  always_comb begin
    unique case (mode_r) inside
      M_HEAD: begin
        mode_fsm = is_nl ? M_LINE : M_HEAD;
      end
      M_SEQ: begin
        mode_fsm = is_nl ? M_PEND : M_SEQ;
      end
      M_PEND, M_LINE: begin
        mode_fsm = is_gt ? M_HEAD : (is_nl ? M_PEND : M_SEQ);
      end
      default: begin
        mode_fsm = M_LINE;
      end
    endcase
    mode_nxt = eof ? M_LINE : mode_fsm;
  end

  always_comb begin
    do_close   = 1'b0;
    do_wr      = 1'b0;
    set_hash   = 1'b0;
    tail_fault = 1'b0;
    wr_byte    = in_data.in_byte;
    unique case (mode_r) inside
      M_HEAD: begin
        do_wr = 1'b1;
        if (is_nl) begin
          wr_byte  = CH_HASH;
          set_hash = 1'b1;
        end else begin
          tail_fault = eof;
        end
      end
      M_SEQ: begin
        if (is_nl) begin
          do_close = eof;
        end else begin
          do_wr      = 1'b1;
          tail_fault = eof;
        end
      end
      M_PEND, M_LINE: begin
        if (is_nl) begin
          do_close = eof;
        end else begin
          do_close   = (mode_r == M_PEND) && is_gt;
          do_wr      = 1'b1;
          tail_fault = eof;
        end
      end
      default: begin
        do_wr = 1'b0;
      end
    endcase
  end

  assign sat0 = (wpos_r == POS_MAX);
  assign p1   = sat0 ? wpos_r : wpos_r + pos_t'(1);
  assign len  = p1 - hash_r - pos_t'(1) - pos_t'(delim_r == CH_NUL);
  assign pw   = do_close ? p1 : wpos_r;
  assign satw = (pw == POS_MAX);
  assign p2   = satw ? pw : pw + pos_t'(1);

  assign first_bad = !seen_r && !is_gt;

  always_comb begin
    wpos_nxt  = do_wr ? p2 : (do_close ? p1 : wpos_r);
    hash_nxt  = set_hash ? pw : hash_r;
    long_nxt  = (do_close && (len > long_r)) ? len : long_r;
    seen_nxt  = !eof;
    fault_nxt = fault_r | first_bad | (do_close & sat0) | (do_wr & satw) | tail_fault;
  end

  always_comb begin
    res = '0;
    res.push = accept;
    res.dual = do_close && do_wr;
    res.first.max_length  = pos_to_out(long_nxt);
    res.first.error       = fault_nxt;
    res.first.last        = !(do_close && do_wr);
    res.second.out_valid  = 1'b1;
    res.second.out_byte   = wr_byte;
    res.second.max_length = pos_to_out(long_nxt);
    res.second.error      = fault_nxt;
    res.second.last       = 1'b1;
    if (do_close) begin
      res.first.out_valid  = 1'b1;
      res.first.out_byte   = delim_r;
      res.first.rec_valid  = 1'b1;
      res.first.rec_offset = pos_to_out(hash_r + pos_t'(1));
      res.first.rec_length = pos_to_out(len);
    end else if (do_wr) begin
      res.first.out_valid = 1'b1;
      res.first.out_byte  = wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= CH_NUL;
    end else if (cfg_we) begin
      delim_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_LINE;
      wpos_r  <= '0;
      hash_r  <= '0;
      long_r  <= '0;
      seen_r  <= 1'b0;
      fault_r <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      wpos_r  <= wpos_nxt;
      hash_r  <= hash_nxt;
      long_r  <= long_nxt;
      seen_r  <= seen_nxt;
      fault_r <= fault_nxt;
    end
  end

  `FPI_ASSERT(a_dual_after_record, clk, rst_n, !res.dual || res.first.rec_valid)
  `FPI_ASSERT_STEP(a_fault_sticky, clk, rst_n, fault_r, fault_r)

endmodule

### hw/rtl/fpi_out_fifo.sv
// Result queue: takes one or two results per transaction, presents one per cycle while nonempty and out_ready is high.
// Depends on fpi_pkg and fasta_pack_and_index_macros.svh.
`timescale 1ns / 1ps
`include "fasta_pack_and_index_macros.svh"

module fpi_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  fpi_pkg::res_push_t res,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output fpi_pkg::out_item_t out_data
);
  import fpi_pkg::*;

  out_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt, wp_plus1;
  logic [FIFO_AW:0]     count_r, count_nxt, n_in;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  always_comb begin
    n_in      = res.push ? (res.dual ? (FIFO_AW+1)'(2) : (FIFO_AW+1)'(1)) : '0;
    wp_plus1  = wp_r + FIFO_AW'(1);
    wp_nxt    = wp_r + n_in[FIFO_AW-1:0];
    rp_nxt    = pop ? rp_r + FIFO_AW'(1) : rp_r;
    count_nxt = count_r + n_in - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      mem_r[wp_r] <= res.first;
    end
    if (res.push && res.dual) begin
      mem_r[wp_plus1] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  `FPI_ASSERT(a_count_bound, clk, rst_n, count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
  `FPI_ASSERT(a_push_has_room, clk, rst_n, !res.push || space_ok)

endmodule

### hw/rtl/fasta_pack_and_index.sv
// Output: each result is registered in the result queue and presented from it in order.
// Throughput: one byte per cycle while in_ready is high; a byte giving two results queues both,
// and input ready drops while the four-entry result queue holds three or more results.
// Reset: synchronous, active low; clears parser state, positions, fault, queue, delimiter.
// Depends on fpi_pkg, fpi_parse and fpi_out_fifo.
`timescale 1ns / 1ps

module fasta_pack_and_index (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpi_pkg::out_item_t out_data
);
  import fpi_pkg::*;

  res_push_t res;
  logic      space_ok;
  logic      accept;

  assign in_ready = space_ok;
  assign accept   = in_valid && space_ok;

  fpi_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_data   (in_data),
    .res       (res)
  );

  fpi_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
